>>> rtl/c8am_pkg.sv
// Shared types, constants and helpers of the 8-bit CPU address-mode decoder.
`timescale 1ns / 1ps

package c8am_pkg;

  // Memory geometry: 64 KiB of bytes.
  localparam int unsigned AddrWidth = 16;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned MemDepth  = 1 << AddrWidth;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InTdataWidth  = 64;
  localparam int unsigned OutTdataWidth = 24;

  // Operation codes carried in the input tuser bit.
  localparam logic OpWrite  = 1'b0;
  localparam logic OpDecode = 1'b1;

  // Addressing modes.
  typedef enum logic [3:0] {
    MODE_ABS   = 4'd0,
    MODE_ABS_X = 4'd1,
    MODE_ABS_Y = 4'd2,
    MODE_IND   = 4'd3,
    MODE_IND_X = 4'd4,
    MODE_IND_Y = 4'd5,
    MODE_REL   = 4'd6,
    MODE_ZP    = 4'd7,
    MODE_ZP_X  = 4'd8,
    MODE_ZP_Y  = 4'd9
  } c8am_mode_e;

  // Request from the sequencer to the byte memory.
  typedef struct packed {
    logic                 we;
    logic [AddrWidth-1:0] waddr;
    logic [DataWidth-1:0] wdata;
    logic                 re;
    logic [AddrWidth-1:0] raddr;
  } c8am_mem_req_t;

  // True for the ten defined addressing modes.
  function automatic logic mode_valid(input logic [3:0] code);
    logic ok;
    case (c8am_mode_e'(code))
      MODE_ABS, MODE_ABS_X, MODE_ABS_Y, MODE_IND, MODE_IND_X,
      MODE_IND_Y, MODE_REL, MODE_ZP, MODE_ZP_X, MODE_ZP_Y: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Number of operand bytes that follow the opcode.
  function automatic logic [1:0] operand_count(input c8am_mode_e m);
    logic [1:0] n;
    case (m)
      MODE_ABS, MODE_ABS_X, MODE_ABS_Y, MODE_IND: n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/cpu8_address_mode_decoder_core.sv
// Top level of the 8-bit CPU effective-address decoder with its byte memory.
// Abs, rel and zero-page decodes run S_OP0, S_OP1, S_OP2 and S_DONE; abs_x/abs_y
// add S_IDX, ind and ind_x add S_P1 and S_P2, and ind_y adds S_P1, S_P2 and S_IDX.
// A new request is taken only in S_IDLE, once the last decode has left S_DONE;
// the single memory read port fetches the dependent bytes one per cycle.
// Memory writes are taken one per cycle in S_IDLE, also while a result waits.
// rst_ni clears the sequencer and the output valid; memory contents are not cleared.
`timescale 1ns / 1ps

module cpu8_address_mode_decoder_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0: mem_address[15:0], mem_data[23:16], mode[27:24],
  // pc[43:28], x_index[51:44], y_index[59:52], zero[63:60].
  input  logic [c8am_pkg::InTdataWidth-1:0]      s_axis_tdata_i,
  // Fields from bit 0: operation.
  input  logic                                   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // Fields from bit 0: effective_address[15:0], extra_cycle[16],
  // operand_bytes[18:17], zero[23:19].
  output logic [c8am_pkg::OutTdataWidth-1:0]     m_axis_tdata_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP0,
    S_OP1,
    S_OP2,
    S_P1,
    S_P2,
    S_IDX,
    S_DONE
  } state_e;

  state_e state_q;

  // Input field unpacking.
  logic [15:0] in_mem_address;
  logic [7:0]  in_mem_data;
  logic [3:0]  in_mode;
  logic [15:0] in_pc;
  logic [7:0]  in_x;
  logic [7:0]  in_y;

  assign in_mem_address = s_axis_tdata_i[15:0];
  assign in_mem_data    = s_axis_tdata_i[23:16];
  assign in_mode        = s_axis_tdata_i[27:24];
  assign in_pc          = s_axis_tdata_i[43:28];
  assign in_x           = s_axis_tdata_i[51:44];
  assign in_y           = s_axis_tdata_i[59:52];

  // Working registers of one decode.
  c8am_pkg::c8am_mode_e mode_q;
  logic [15:0] pc_q;
  logic [15:0] pc1_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [7:0]  lo_q;
  logic [15:0] ptr_q;
  logic [15:0] base_q;
  logic [15:0] res_ea_q;
  logic        res_extra_q;
  logic [1:0]  res_nb_q;

  // Output register.
  logic        out_valid_q;
  logic [15:0] out_ea_q;
  logic        out_extra_q;
  logic [1:0]  out_nb_q;

  logic s_fire;
  logic m_fire;
  logic out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_valid_q && m_axis_tready_i;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Memory port and its read data.
  c8am_pkg::c8am_mem_req_t mem_req;
  logic [7:0]              rdata;

  c8am_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Shared 16-bit adder: operand selection per sequencer step.
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] add_sum;

  always_comb begin
    add_a = 16'h0000;
    add_b = 16'h0000;
    case (state_q)
      S_OP0: begin
        add_a = pc_q;
        add_b = 16'h0001;
      end
      S_OP2: begin
        case (mode_q)
          c8am_pkg::MODE_IND_X, c8am_pkg::MODE_ZP_X: begin
            add_a = {8'h00, lo_q};
            add_b = {8'h00, x_q};
          end
          c8am_pkg::MODE_ZP_Y: begin
            add_a = {8'h00, lo_q};
            add_b = {8'h00, y_q};
          end
          c8am_pkg::MODE_REL: begin
            add_a = pc1_q;
            add_b = {{8{lo_q[7]}}, lo_q};
          end
          default: begin
            add_a = 16'h0000;
            add_b = 16'h0000;
          end
        endcase
      end
      S_P1: begin
        add_a = {8'h00, ptr_q[7:0]};
        add_b = 16'h0001;
      end
      S_IDX: begin
        add_a = base_q;
        add_b = (mode_q == c8am_pkg::MODE_ABS_X) ? {8'h00, x_q} : {8'h00, y_q};
      end
      default: begin
        add_a = 16'h0000;
        add_b = 16'h0000;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // Memory request: writes in idle, operand and pointer reads while decoding.
  always_comb begin
    mem_req       = '0;
    mem_req.we    = s_fire && (s_axis_tuser_i == c8am_pkg::OpWrite);
    mem_req.waddr = in_mem_address;
    mem_req.wdata = in_mem_data;
    case (state_q)
      S_OP0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = pc_q;
      end
      S_OP1: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = pc1_q;
      end
      S_OP2: begin
        case (mode_q)
          c8am_pkg::MODE_IND: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {rdata, lo_q};
          end
          c8am_pkg::MODE_IND_X: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {8'h00, add_sum[7:0]};
          end
          c8am_pkg::MODE_IND_Y: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = {8'h00, lo_q};
          end
          default: begin
            mem_req.re = 1'b0;
          end
        endcase
      end
      S_P1: begin
        // The pointer high byte stays in the page of the low byte.
        mem_req.re    = 1'b1;
        mem_req.raddr = {ptr_q[15:8], add_sum[7:0]};
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  // Sequencer with its working and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= c8am_pkg::MODE_ABS;
      pc_q        <= '0;
      pc1_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      lo_q        <= '0;
      ptr_q       <= '0;
      base_q      <= '0;
      res_ea_q    <= '0;
      res_extra_q <= 1'b0;
      res_nb_q    <= '0;
      out_valid_q <= 1'b0;
      out_ea_q    <= '0;
      out_extra_q <= 1'b0;
      out_nb_q    <= '0;
    end else begin
      // Output valid rises when a result is handed over and falls when it is taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire && (s_axis_tuser_i == c8am_pkg::OpDecode) &&
              c8am_pkg::mode_valid(in_mode)) begin
            mode_q  <= c8am_pkg::c8am_mode_e'(in_mode);
            pc_q    <= in_pc;
            x_q     <= in_x;
            y_q     <= in_y;
            state_q <= S_OP0;
          end
        end
        S_OP0: begin
          pc1_q   <= add_sum;
          state_q <= S_OP1;
        end
        S_OP1: begin
          lo_q    <= rdata;
          state_q <= S_OP2;
        end
        S_OP2: begin
          // Only a branch can cross a page here; indexed modes decide in S_IDX.
          res_extra_q <= (mode_q == c8am_pkg::MODE_REL) &&
                         (pc1_q[15:8] != add_sum[15:8]);
          res_nb_q    <= c8am_pkg::operand_count(mode_q);
          case (mode_q)
            c8am_pkg::MODE_ABS: begin
              res_ea_q <= {rdata, lo_q};
              state_q  <= S_DONE;
            end
            c8am_pkg::MODE_ABS_X, c8am_pkg::MODE_ABS_Y: begin
              base_q  <= {rdata, lo_q};
              state_q <= S_IDX;
            end
            c8am_pkg::MODE_IND: begin
              ptr_q   <= {rdata, lo_q};
              state_q <= S_P1;
            end
            c8am_pkg::MODE_IND_X: begin
              ptr_q   <= {8'h00, add_sum[7:0]};
              state_q <= S_P1;
            end
            c8am_pkg::MODE_IND_Y: begin
              ptr_q   <= {8'h00, lo_q};
              state_q <= S_P1;
            end
            c8am_pkg::MODE_REL: begin
              res_ea_q <= add_sum;
              state_q  <= S_DONE;
            end
            c8am_pkg::MODE_ZP: begin
              res_ea_q <= {8'h00, lo_q};
              state_q  <= S_DONE;
            end
            c8am_pkg::MODE_ZP_X, c8am_pkg::MODE_ZP_Y: begin
              res_ea_q <= {8'h00, add_sum[7:0]};
              state_q  <= S_DONE;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_P1: begin
          lo_q    <= rdata;
          state_q <= S_P2;
        end
        S_P2: begin
          if (mode_q == c8am_pkg::MODE_IND_Y) begin
            base_q  <= {rdata, lo_q};
            state_q <= S_IDX;
          end else begin
            res_ea_q <= {rdata, lo_q};
            state_q  <= S_DONE;
          end
        end
        S_IDX: begin
          res_ea_q    <= add_sum;
          res_extra_q <= (base_q[15:8] != add_sum[15:8]);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (out_free) begin
            out_ea_q    <= res_ea_q;
            out_extra_q <= res_extra_q;
            out_nb_q    <= res_nb_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_nb_q, out_extra_q, out_ea_q};

  // A finished result waits in S_DONE while the output register is occupied.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
    else $error("decode result left S_DONE while the output was busy");

  // Leaving S_DONE always presents a result.
  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (m_axis_tvalid_o && state_q == S_IDLE))
    else $error("result not presented after S_DONE");

  // A decode request of a defined mode starts the operand fetch.
  a_decode_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tuser_i == c8am_pkg::OpDecode && c8am_pkg::mode_valid(in_mode))
    |=> (state_q == S_OP0))
    else $error("decode request did not start the sequencer");

  // The memory port never writes while a decode reads it.
  a_no_write_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("memory write collided with a decode read");

  // Indexing takes one adder step and then finishes.
  a_idx_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDX) |=> (state_q == S_DONE))
    else $error("index step did not finish the decode");

endmodule

>>> rtl/c8am_mem.sv
// 64 KiB byte memory with one write port and one registered read port.
`timescale 1ns / 1ps

module c8am_mem (
  input  logic                                clk_i,
  input  c8am_pkg::c8am_mem_req_t             req_i,
  output logic [c8am_pkg::DataWidth-1:0]      rdata_o
);

  logic [c8am_pkg::DataWidth-1:0] mem_q [c8am_pkg::MemDepth];
  logic [c8am_pkg::DataWidth-1:0] rdata_q;

  // Byte write.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> dv/cpu8_address_mode_decoder_core_tb.sv
// Self-checking stream testbench for the 8-bit CPU effective-address decoder.
`timescale 1ns / 1ps

module cpu8_address_mode_decoder_core_tb;

  // Unused mode codes at both ends of the spare range.
  localparam logic [3:0] ModeSpareLo = 4'd10;
  localparam logic [3:0] ModeSpareHi = 4'd15;

  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned PhaseItems   = 200;
  localparam int unsigned SinkHoldOff  = 400;
  localparam int unsigned DrainCycles  = 16;

  // One input request, in stream field order.
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  mode;
    logic [15:0] pc;
    logic [7:0]  x;
    logic [7:0]  y;
  } bus_req_t;

  // One decoded address as the block returns it.
  typedef struct packed {
    logic [15:0] ea;
    logic        extra;
    logic [1:0]  nbytes;
  } addr_result_t;

  // A result typed into the directed table, or none.
  typedef struct packed {
    bit           is_typed;
    addr_result_t value;
  } pinned_result_t;

  typedef struct packed {
    bus_req_t       req;
    pinned_result_t pin;
  } stim_row_t;

  typedef enum int {
    PH_STREAM,
    PH_SEND_GAPS,
    PH_SINK_STALLS,
    PH_BOTH,
    PH_BACKPRESSURE
  } phase_e;

  localparam pinned_result_t NoPin = '0;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [c8am_pkg::InTdataWidth-1:0]  s_tdata = '0;
  logic                               s_tuser = 1'b0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [c8am_pkg::OutTdataWidth-1:0] m_tdata;

  phase_e phase = PH_STREAM;
  int unsigned error_count = 0;
  int unsigned random_items = 0;
  int unsigned write_count = 0;
  int unsigned spare_count = 0;
  int unsigned cross_count = 0;
  int unsigned mode_hits [10];

  // Byte memory as the generator plans it, and as the checker tracks it.
  logic [7:0] plan_mem   [0:65535];
  bit         plan_written [0:65535];
  logic [7:0] shadow_mem [0:65535];

  addr_result_t   pending_decode_q [$];
  pinned_result_t pinned_result_q [$];

  // Walked in order: each special case sits right after the writes it needs.
  stim_row_t directed_rows [25] = '{
    '{'{c8am_pkg::OpWrite, 16'h1000, 8'h34, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h1001, 8'h12, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ABS, 16'h1000, 8'h00, 8'h00},
      '{1'b1, '{16'h1234, 1'b0, 2'd2}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ABS_X, 16'h1000, 8'hFF, 8'h00},
      '{1'b1, '{16'h1333, 1'b1, 2'd2}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ABS_Y, 16'h1000, 8'h00, 8'h00},
      '{1'b1, '{16'h1234, 1'b0, 2'd2}}},
    '{'{c8am_pkg::OpWrite, 16'hFFFF, 8'hFF, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h0000, 8'hFF, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    // Operand fetch wraps from the top of memory to address zero.
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ABS_X, 16'hFFFF, 8'h01, 8'h00},
      '{1'b1, '{16'h0000, 1'b1, 2'd2}}},
    '{'{c8am_pkg::OpWrite, 16'h2000, 8'hFF, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h2001, 8'h30, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h30FF, 8'h78, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h3000, 8'h56, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    // Indirect jump through a pointer at the end of a page.
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_IND, 16'h2000, 8'h00, 8'h00},
      NoPin},
    '{'{c8am_pkg::OpWrite, 16'h4000, 8'hF0, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpWrite, 16'h00FF, 8'hCD, 4'd0, 16'h0000, 8'h00, 8'h00}, NoPin},
    // Pre-indexed pointer lands on the last zero-page byte and wraps.
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_IND_X, 16'h4000, 8'h0F, 8'h00},
      '{1'b1, '{16'hFFCD, 1'b0, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_IND_Y, 16'hFFFF, 8'h00, 8'h40},
      NoPin},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_REL, 16'h1000, 8'h00, 8'h00},
      '{1'b1, '{16'h1035, 1'b0, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_REL, 16'hFFFF, 8'h00, 8'h00},
      '{1'b1, '{16'hFFFF, 1'b1, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_REL, 16'h4000, 8'h00, 8'h00},
      NoPin},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ZP, 16'h2000, 8'h00, 8'h00},
      '{1'b1, '{16'h00FF, 1'b0, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ZP_X, 16'h2000, 8'h01, 8'h00},
      '{1'b1, '{16'h0000, 1'b0, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, c8am_pkg::MODE_ZP_Y, 16'h4000, 8'h00, 8'h20},
      '{1'b1, '{16'h0010, 1'b0, 2'd1}}},
    '{'{c8am_pkg::OpDecode, 16'h0000, 8'h00, ModeSpareLo, 16'h1000, 8'h00, 8'h00}, NoPin},
    '{'{c8am_pkg::OpDecode, 16'hFFFF, 8'hFF, ModeSpareHi, 16'hFFFF, 8'hFF, 8'hFF}, NoPin}
  };

  cpu8_address_mode_decoder_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Timeout with %0d decodes still pending.", pending_decode_q.size());
    $display("cpu8_address_mode_decoder_core regression: fail");
    $finish;
  end

  function automatic int unsigned send_gap_pct(input phase_e p);
    case (p)
      PH_SEND_GAPS: return 60;
      PH_BOTH:      return 13;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(input phase_e p);
    case (p)
      PH_SINK_STALLS: return 60;
      PH_BOTH:        return 13;
      default:        return 0;
    endcase
  endfunction

  function automatic phase_e phase_for(input int unsigned n);
    case (n / PhaseItems)
      0:       return PH_SEND_GAPS;
      1:       return PH_SINK_STALLS;
      2:       return PH_BOTH;
      3:       return PH_BACKPRESSURE;
      default: return PH_STREAM;
    endcase
  endfunction

  // Bytes leaning toward the page and sign boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Operand addresses leaning toward memory top, page zero and page ends.
  function automatic logic [15:0] pick_pc();
    case ($urandom_range(7))
      0:       return 16'hFFFF;
      1:       return {8'h00, pick_byte()};
      2:       return {8'($urandom), 8'hFF};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bus_req_t random_req();
    bus_req_t r;
    r.op   = 1'($urandom);
    r.addr = 16'($urandom);
    r.data = 8'($urandom);
    r.mode = 4'($urandom);
    r.pc   = 16'($urandom);
    r.x    = 8'($urandom);
    r.y    = 8'($urandom);
    return r;
  endfunction

  // Effective address, page-cross flag and operand length of one decode.
  function automatic addr_result_t resolve_address(input logic [3:0] mode,
                                                   input logic [15:0] pc,
                                                   input logic [7:0] x,
                                                   input logic [7:0] y);
    addr_result_t r;
    logic [15:0] pc_next;
    logic [15:0] base;
    logic [15:0] ptr;
    logic [7:0]  zp;
    logic [7:0]  off;
    pc_next  = pc + 16'd1;
    r.ea     = '0;
    r.extra  = 1'b0;
    r.nbytes = 2'd1;
    case (c8am_pkg::c8am_mode_e'(mode))
      c8am_pkg::MODE_ABS: begin
        r.ea     = {shadow_mem[pc_next], shadow_mem[pc]};
        r.nbytes = 2'd2;
      end
      c8am_pkg::MODE_ABS_X, c8am_pkg::MODE_ABS_Y: begin
        base     = {shadow_mem[pc_next], shadow_mem[pc]};
        r.ea     = base + {8'h00, (mode == c8am_pkg::MODE_ABS_X) ? x : y};
        r.extra  = (base[15:8] != r.ea[15:8]);
        r.nbytes = 2'd2;
      end
      c8am_pkg::MODE_IND: begin
        // The high pointer byte never leaves the page of the low one.
        ptr      = {shadow_mem[pc_next], shadow_mem[pc]};
        r.ea     = {shadow_mem[{ptr[15:8], ptr[7:0] + 8'd1}], shadow_mem[ptr]};
        r.nbytes = 2'd2;
      end
      c8am_pkg::MODE_IND_X: begin
        zp   = shadow_mem[pc] + x;
        r.ea = {shadow_mem[{8'h00, zp + 8'd1}], shadow_mem[{8'h00, zp}]};
      end
      c8am_pkg::MODE_IND_Y: begin
        zp      = shadow_mem[pc];
        base    = {shadow_mem[{8'h00, zp + 8'd1}], shadow_mem[{8'h00, zp}]};
        r.ea    = base + {8'h00, y};
        r.extra = (base[15:8] != r.ea[15:8]);
      end
      c8am_pkg::MODE_REL: begin
        off     = shadow_mem[pc];
        r.ea    = pc_next + {{8{off[7]}}, off};
        r.extra = (pc_next[15:8] != r.ea[15:8]);
      end
      c8am_pkg::MODE_ZP:   r.ea = {8'h00, shadow_mem[pc]};
      c8am_pkg::MODE_ZP_X: begin
        zp   = shadow_mem[pc] + x;
        r.ea = {8'h00, zp};
      end
      c8am_pkg::MODE_ZP_Y: begin
        zp   = shadow_mem[pc] + y;
        r.ea = {8'h00, zp};
      end
      default: r.ea = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one request, idling first as the phase asks, until it is taken.
  task automatic offer_request(input bus_req_t r, input pinned_result_t pin,
                               input bit counted);
    while ($urandom_range(99) < send_gap_pct(phase)) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    if (r.op == c8am_pkg::OpWrite) begin
      plan_mem[r.addr]     = r.data;
      plan_written[r.addr] = 1'b1;
    end
    pinned_result_q.push_back(pin);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, r.y, r.x, r.pc, r.mode, r.data, r.addr};
    s_tuser  <= r.op;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (counted) random_items++;
  endtask

  // Make sure a byte is written before a decode reads it, sometimes rewriting it.
  task automatic prepare_byte(input logic [15:0] where, input bit may_rewrite);
    bus_req_t w;
    if (!plan_written[where] || (may_rewrite && $urandom_range(3) == 0)) begin
      w      = random_req();
      w.op   = c8am_pkg::OpWrite;
      w.addr = where;
      w.data = pick_byte();
      offer_request(w, NoPin, 1'b1);
    end
  endtask

  // Writes for operand and pointer bytes, then the decode that reads them.
  task automatic decode_sequence();
    bus_req_t    d;
    logic [15:0] pc_next;
    logic [15:0] ptr;
    logic [15:0] ptr_hi;
    logic [7:0]  zp;
    d       = random_req();
    d.op    = c8am_pkg::OpDecode;
    d.mode  = 4'($urandom_range(9));
    d.pc    = pick_pc();
    d.x     = pick_byte();
    d.y     = pick_byte();
    pc_next = d.pc + 16'd1;
    prepare_byte(d.pc, 1'b1);
    if (d.mode <= c8am_pkg::MODE_IND) prepare_byte(pc_next, 1'b1);
    // Pointer bytes that alias an operand byte are left as they are.
    case (c8am_pkg::c8am_mode_e'(d.mode))
      c8am_pkg::MODE_IND: begin
        ptr    = {plan_mem[pc_next], plan_mem[d.pc]};
        ptr_hi = {ptr[15:8], ptr[7:0] + 8'd1};
        prepare_byte(ptr, ptr != d.pc && ptr != pc_next);
        prepare_byte(ptr_hi, ptr_hi != d.pc && ptr_hi != pc_next);
      end
      c8am_pkg::MODE_IND_X, c8am_pkg::MODE_IND_Y: begin
        zp = plan_mem[d.pc] + ((d.mode == c8am_pkg::MODE_IND_X) ? d.x : 8'h00);
        prepare_byte({8'h00, zp}, {8'h00, zp} != d.pc);
        zp = zp + 8'd1;
        prepare_byte({8'h00, zp}, {8'h00, zp} != d.pc);
      end
      default: ;
    endcase
    offer_request(d, NoPin, 1'b1);
  endtask

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_BACKPRESSURE && !held) begin
        hold_left = SinkHoldOff;
        held      = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct(phase));
      end
    end
  end

  // Track accepted requests and check returned decodes in order.
  always @(posedge clk_i) begin
    pinned_result_t pin;
    addr_result_t   want;
    logic [3:0]     mode;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        pin  = pinned_result_q.pop_front();
        mode = s_tdata[27:24];
        if (s_tuser == c8am_pkg::OpWrite) begin
          shadow_mem[s_tdata[15:0]] = s_tdata[23:16];
          write_count++;
        end else if (mode <= c8am_pkg::MODE_ZP_Y) begin
          want = pin.is_typed ? pin.value
                              : resolve_address(mode, s_tdata[43:28], s_tdata[51:44],
                                                s_tdata[59:52]);
          pending_decode_q.push_back(want);
          mode_hits[mode]++;
        end else begin
          spare_count++;
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_decode_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[15:0], 16'h0000);
        end else begin
          want = pending_decode_q.pop_front();
          if (m_tdata[15:0] != want.ea)
            report_mismatch("effective_address", m_tdata[15:0], want.ea);
          if (m_tdata[16] != want.extra)
            report_mismatch("extra_cycle", 16'(m_tdata[16]), 16'(want.extra));
          if (m_tdata[18:17] != want.nbytes)
            report_mismatch("operand_bytes", 16'(m_tdata[18:17]), 16'(want.nbytes));
          if (m_tdata[23:19] != '0)
            report_mismatch("padding", 16'(m_tdata[23:19]), 16'h0000);
          if (want.extra) cross_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    bus_req_t r;
    int unsigned pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) offer_request(directed_rows[i].req, directed_rows[i].pin, 1'b0);

    // Mostly well-formed decode sequences, with stray writes and spare modes.
    while (random_items < RandomItems) begin
      phase = phase_for(random_items);
      pick  = $urandom_range(9);
      if (pick == 0) begin
        r    = random_req();
        r.op = c8am_pkg::OpWrite;
        offer_request(r, NoPin, 1'b1);
      end else if (pick == 1) begin
        r      = random_req();
        r.op   = c8am_pkg::OpDecode;
        r.mode = 4'($urandom_range(ModeSpareHi, ModeSpareLo));
        offer_request(r, NoPin, 1'b0);
      end else begin
        decode_sequence();
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending_decode_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d byte writes, %0d ignored spare-mode requests, %0d page crosses.",
             write_count, spare_count, cross_count);
    $display("Decodes per mode abs..zp_y: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
             mode_hits[5], mode_hits[6], mode_hits[7], mode_hits[8], mode_hits[9]);
    if (error_count == 0) begin
      $display("cpu8_address_mode_decoder_core regression: pass");
    end else begin
      $display("cpu8_address_mode_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/c8am_pkg.sv
rtl/c8am_mem.sv
rtl/cpu8_address_mode_decoder_core.sv
dv/cpu8_address_mode_decoder_core_tb.sv
